// ===== rtl/float_to_minifloat_pack_assert.svh =====
// Assertion macros for the float to minifloat packer.
`ifndef FLOAT_TO_MINIFLOAT_PACK_ASSERT_SVH
`define FLOAT_TO_MINIFLOAT_PACK_ASSERT_SVH
`ifndef SYNTHESIS
`define FMP_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FMP_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FMP_ASSERT_IMP(label, a, c)
`define FMP_ASSERT_NXT(label, a, c)
`endif
`endif

// ===== rtl/fmp_pkg.sv =====
// Shared types and constants for the float to minifloat packer.
package fmp_pkg;
    localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [30:0] INF_MAG = 31'h7F80_0000;
    localparam logic [7:0] FEXP_BIAS = 8'd127;
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;
    localparam logic CFG_EXP_WIDTH = 1'b0;
    localparam logic CFG_MAN_WIDTH = 1'b1;

    typedef struct packed {
        logic [3:0] ew;
        logic [4:0] mw;
    } widths_t;

    // Rebuild float bits from a code at the given (in range) widths.
    function automatic logic [31:0] unpack_code(input logic [31:0] code,
                                                input logic [3:0] ew,
                                                input logic [4:0] mw);
        logic [31:0] c;
        logic s;
        logic eneg;
        logic [7:0] emag;
        logic [22:0] man;
        logic [7:0] bexp;
        logic [5:0] total;
        begin
            // a full-width code needs all 32 bits, so keep a sixth bit here
            total = 6'(ew) + 6'(mw) + 6'd1;
            c = code & ~(32'hFFFF_FFFF << total);
            s = c[5'(ew) + mw];
            eneg = c[5'(ew) - 5'd1 + mw];
            emag = 8'((c >> mw) & ((32'd1 << (ew - 4'd1)) - 32'd1));
            man = 23'((c & ((32'd1 << mw) - 32'd1)) << (5'd23 - mw));
            bexp = eneg ? (FEXP_BIAS - emag) : (FEXP_BIAS + emag);
            unpack_code = {s, bexp, man};
        end
    endfunction
endpackage

// ===== rtl/float_to_minifloat_pack.sv =====
// Top level of the float to minifloat packer.
// Converts IEEE single float bits to a packed minifloat code (func 0) or a
// code back to float bits (func 1). Input channel: in_valid/in_stall with
// func and operand_bits; output channel: out_valid/out_stall with result_bits.
// A transaction is taken when valid is high and stall is low.
// The input transaction is captured in the input register, then the converted
// result in the result register; a receiver stall can hold it in the input
// register. Throughput: one transaction per cycle while out_stall is low,
// with a single conversion stage between the two registers.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 exponent_width,
// 1 mantissa_width) and cfg_data; write only while idle. cfg_ready is high.
// Reset clears both valid flags and sets widths to 8 and 23.
// When the receiver stalls, the result register holds and the input stage
// fills; in_stall rises only once both stages are full.
`include "float_to_minifloat_pack_assert.svh"
module float_to_minifloat_pack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    fmp_pkg::widths_t eff;
    logic s1_valid_reg, out_valid_reg;
    logic func_reg;
    logic [31:0] op_reg, res_reg, conv_res;
    logic out_take, s1_adv;

    fmp_cfg u_cfg (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .eff);
    fmp_conv u_conv (.func(func_reg), .operand(op_reg), .w(eff), .result(conv_res));

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_adv = out_take;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign out_valid = out_valid_reg;
    assign result_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take) out_valid_reg <= s1_valid_reg;
            if (!in_stall) s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg <= func;
            op_reg <= operand_bits;
        end
        if (out_take && s1_valid_reg) res_reg <= conv_res;
    end

    `FMP_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(result_bits))
    `FMP_ASSERT_IMP(a_stall, in_stall, s1_valid_reg && out_valid_reg)
    `FMP_ASSERT_NXT(a_move, s1_valid_reg && !in_stall, out_valid)
endmodule

// ===== rtl/fmp_cfg.sv =====
// Width registers with write port and saturated effective widths.
module fmp_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [4:0]      cfg_data,
    output fmp_pkg::widths_t eff
);
    logic [3:0] ew_reg;
    logic [4:0] mw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg <= 4'd8;
            mw_reg <= 5'd23;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == fmp_pkg::CFG_EXP_WIDTH) ew_reg <= cfg_data[3:0];
            else mw_reg <= cfg_data;
        end
    end

    // clamp to the legal ranges at use
    always_comb
    begin
        eff.ew = (ew_reg < 4'd2) ? 4'd2 : ((ew_reg > 4'd8) ? 4'd8 : ew_reg);
        eff.mw = (mw_reg < 5'd2) ? 5'd2 : ((mw_reg > 5'd23) ? 5'd23 : mw_reg);
    end
endmodule

// ===== rtl/fmp_conv.sv =====
// Combinational encode and decode datapath.
module fmp_conv (
    input  logic             func,
    input  logic [31:0]      operand,
    input  fmp_pkg::widths_t w,
    output logic [31:0]      result
);
    logic [31:0] max_code, min_code, sign_bit, max_mag, min_mag, a, packed_v;
    logic [7:0] bexp, emag;
    logic eneg, s, neg;
    logic [3:0] mb;

    always_comb
    begin
        mb = w.ew - 4'd1;
        max_code = (((32'd1 << mb) - 32'd1) << w.mw) | ((32'd1 << w.mw) - 32'd1);
        min_code = (((32'd1 << w.ew) - 32'd2) << w.mw) | 32'd1;
        sign_bit = 32'd1 << (5'(w.ew) + w.mw);
        max_mag = fmp_pkg::unpack_code(max_code, w.ew, w.mw) & fmp_pkg::MAG_MASK;
        min_mag = fmp_pkg::unpack_code(min_code, w.ew, w.mw) & fmp_pkg::MAG_MASK;
        a = operand & fmp_pkg::MAG_MASK;
        s = operand[31];
        neg = s && (a != 32'd0);
        bexp = operand[30:23];
        eneg = bexp < fmp_pkg::FEXP_BIAS;
        emag = eneg ? (fmp_pkg::FEXP_BIAS - bexp) : (bexp - fmp_pkg::FEXP_BIAS);
        packed_v = (32'(s) << (5'(w.ew) + w.mw))
                 | (((32'(eneg) << mb) | (32'(emag) & ((32'd1 << mb) - 32'd1))) << w.mw)
                 | (32'(operand[22:0]) >> (5'd23 - w.mw));
        if (func == fmp_pkg::FUNC_DECODE)
            result = fmp_pkg::unpack_code(operand, w.ew, w.mw);
        else if (a[30:0] <= fmp_pkg::INF_MAG && a >= max_mag)
            result = neg ? (max_code | sign_bit) : max_code;
        else if (a[30:0] <= fmp_pkg::INF_MAG && a <= min_mag)
            result = neg ? (min_code | sign_bit) : min_code;
        else
            result = packed_v;
    end
endmodule
